// ----- hdl/log_bucket_latency_histogram_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the latency histogram
// Concurrent check wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LOG_BUCKET_LATENCY_HISTOGRAM_TOP_DEFINES_SVH
`define LOG_BUCKET_LATENCY_HISTOGRAM_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that a property holds at every clock edge out of reset.
`define LBH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition never holds at a clock edge out of reset.
`define LBH_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define LBH_ASSERT(lbl, prop, msg)
`define LBH_NEVER(lbl, cond, msg)
`endif

`endif

// ----- hdl/lbh_pkg.sv -----
// ----------------------------------------------------------------------------
// Latency histogram package
// Field widths and the quarter-octave bucket bound function.
// ----------------------------------------------------------------------------
package lbh_pkg;

	localparam int BUCKETS_DEF = 128;

	localparam int NS_W    = 48;
	localparam int CNT_W   = 32;
	localparam int SUM_W   = 64;
	localparam int QF_W    = 17;
	localparam int BOUND_W = NS_W + 1;

	localparam logic [QF_W-1:0]    Q_ONE     = QF_W'(65536);
	localparam logic [BOUND_W-1:0] BOUND_SAT = {1'b1, {NS_W{1'b0}}};
	localparam logic [63:0]        BILLION   = 64'd1000000000;

	// Upper bound of bucket k: round(10000 * 2^(k/4)) ns, held at 2^48.
	function automatic logic [BOUND_W-1:0] bound_of(input int k);
		logic [63:0] whole;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [63:0] a;
		logic [63:0] bq;
		logic [63:0] s;
		logic [63:0] v;
		int          r;
		int          m;
		r = k & 3;
		m = k >> 2;
		unique case (r)
			0: begin
				whole = 64'd10000; hi = 64'd0;         lo = 64'd0;
			end
			1: begin
				whole = 64'd11892; hi = 64'd71150027;  lo = 64'd210667175;
			end
			2: begin
				whole = 64'd14142; hi = 64'd135623730; lo = 64'd950488017;
			end
			default: begin
				whole = 64'd16817; hi = 64'd928305074; lo = 64'd290860623;
			end
		endcase
		if (m > 34) begin
			return BOUND_SAT;
		end
		a  = hi << m;
		bq = (lo << m) / BILLION;
		s  = a + bq;
		v  = (whole << m) + (s + BILLION / 64'd2) / BILLION;
		if (v > 64'(BOUND_SAT)) begin
			return BOUND_SAT;
		end
		return v[BOUND_W-1:0];
	endfunction

endpackage

// ----- hdl/lbh_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lbh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/log_bucket_latency_histogram_top.sv -----
// Add beat: busy through the bound search, then the count read and write back;
//   a sample dropped at full count leaves busy low.
// Query beat: busy only for the result step on an empty store, else also through the multiply,
//   the rounding and a walk of one bucket per RAM read; result_valid is high for one cycle, the first with busy low.
// Reset: a clearing pass writes zero to every bucket with busy high.
// The receiver cannot stall; every result is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
// Log-bucket latency histogram
// Quarter-octave histogram of ns latencies with count, saturating sum, min,
// max and quantile queries; bucket counts live in one synchronous RAM.
// ----------------------------------------------------------------------------
`include "log_bucket_latency_histogram_top_defines.svh"

module log_bucket_latency_histogram_top #(
	parameter int BUCKETS = lbh_pkg::BUCKETS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       mode,
	input  logic [lbh_pkg::NS_W-1:0]   sample_ns,
	input  logic [lbh_pkg::QF_W-1:0]   quantile_fraction,
	output logic                       result_valid,
	output logic [lbh_pkg::NS_W-1:0]   quantile_ns,
	output logic [lbh_pkg::CNT_W-1:0]  sample_count,
	output logic [lbh_pkg::SUM_W-1:0]  sum_ns,
	output logic [lbh_pkg::NS_W-1:0]   min_ns,
	output logic [lbh_pkg::NS_W-1:0]   max_ns
);

	localparam int IDXW = $clog2(BUCKETS);
	localparam int NS_W = lbh_pkg::NS_W;
	localparam int CNT_W = lbh_pkg::CNT_W;
	localparam int SUM_W = lbh_pkg::SUM_W;
	localparam int QF_W = lbh_pkg::QF_W;
	localparam int BOUND_W = lbh_pkg::BOUND_W;
	localparam int PROD_W = QF_W + CNT_W;
	localparam logic [IDXW-1:0] LAST = IDXW'(BUCKETS - 1);
	localparam logic [IDXW-1:0] MSB_BIT = {1'b1, {(IDXW-1){1'b0}}};

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SEARCH,
		S_RD,
		S_WR,
		S_MUL,
		S_CEIL,
		S_WALK,
		S_RESULT
	} state_t;

	state_t                state_q;

	// Bucket index: search result for adds, clear sweep, read pointer of the walk.
	logic [IDXW-1:0]       idx_q;
	logic [IDXW-1:0]       bit_q;
	logic [NS_W-1:0]       sample_q;
	logic [QF_W-1:0]       qf_q;
	logic [PROD_W-1:0]     prod_q;
	logic [CNT_W-1:0]      target_q;
	logic [CNT_W-1:0]      cum_q;
	logic                  rvld_s1;
	logic [IDXW-1:0]       dat_idx_s1;
	logic [IDXW-1:0]       found_q;

	logic [CNT_W-1:0]      count_q;
	logic [SUM_W-1:0]      sum_q;
	logic [NS_W-1:0]       min_q;
	logic [NS_W-1:0]       max_q;

	logic                  result_valid_q;
	logic [NS_W-1:0]       quantile_q;
	logic [CNT_W-1:0]      sample_count_q;
	logic [SUM_W-1:0]      sum_out_q;
	logic [NS_W-1:0]       min_out_q;
	logic [NS_W-1:0]       max_out_q;

	logic                  ram_we;
	logic [IDXW-1:0]       ram_waddr;
	logic [CNT_W-1:0]      ram_wdata;
	logic [IDXW-1:0]       ram_raddr;
	logic [CNT_W-1:0]      ram_rdata;

	logic [BOUND_W-1:0]    bound_w [BUCKETS];

	logic                  accept;
	logic [IDXW-1:0]       cand;
	logic [IDXW-1:0]       cand_m1;
	logic                  cand_hit;
	logic [SUM_W:0]        sum_add;
	logic [PROD_W-1:0]     prod_ceil;
	logic [CNT_W-1:0]      target_n;
	logic [CNT_W:0]        cum_add;
	logic                  walk_stop;
	logic [BOUND_W-1:0]    found_bound;
	logic [NS_W-1:0]       quantile_n;

	// Bound table, folded to constants at elaboration.
	for (genvar g = 0; g < BUCKETS; g++) begin : g_bound
		assign bound_w[g] = lbh_pkg::bound_of(g);
	end

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// Binary search: try the next lower index bit, keep it if the sample
	// reaches the bound just below the candidate bucket.
	assign cand     = idx_q | bit_q;
	assign cand_m1  = cand - IDXW'(1);
	assign cand_hit = (cand <= LAST) && ({1'b0, sample_q} >= bound_w[cand_m1]);

	assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(sample_ns);

	// Round the quantile target up and keep it at one or more.
	assign prod_ceil = prod_q + PROD_W'(65535);
	assign target_n  = (prod_ceil[PROD_W-1:16] == '0) ? CNT_W'(1)
	                                                  : prod_ceil[16 +: CNT_W];

	// Running sum of bucket counts as they come back from the RAM.
	assign cum_add   = {1'b0, cum_q} + {1'b0, ram_rdata};
	assign walk_stop = rvld_s1 && ((cum_add[CNT_W-1:0] >= target_q) || (dat_idx_s1 == LAST));

	// Quantile: zero when empty, max for the open bucket, else bound capped by max.
	assign found_bound = bound_w[found_q];
	always_comb begin
		if (count_q == '0) begin
			quantile_n = '0;
		end else if (found_q == LAST) begin
			quantile_n = max_q;
		end else if (found_bound < {1'b0, max_q}) begin
			quantile_n = found_bound[NS_W-1:0];
		end else begin
			quantile_n = max_q;
		end
	end

	// RAM port steering: clear sweep and count write back share the write port.
	always_comb begin
		ram_we    = (state_q == S_CLEAR) || (state_q == S_WR);
		ram_waddr = idx_q;
		ram_wdata = (state_q == S_WR) ? ram_rdata + CNT_W'(1) : '0;
		ram_raddr = idx_q;
	end

	lbh_ram #(
		.WIDTH (CNT_W),
		.DEPTH (BUCKETS)
	) u_counts (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			idx_q          <= '0;
			bit_q          <= MSB_BIT;
			sample_q       <= '0;
			qf_q           <= '0;
			prod_q         <= '0;
			target_q       <= '0;
			cum_q          <= '0;
			rvld_s1        <= 1'b0;
			dat_idx_s1     <= '0;
			found_q        <= '0;
			count_q        <= '0;
			sum_q          <= '0;
			min_q          <= '0;
			max_q          <= '0;
			result_valid_q <= 1'b0;
			quantile_q     <= '0;
			sample_count_q <= '0;
			sum_out_q      <= '0;
			min_out_q      <= '0;
			max_out_q      <= '0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					// Sweep zeros through the bucket RAM.
					idx_q <= idx_q + IDXW'(1);
					if (idx_q == LAST) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept && !mode) begin
						// Drop the sample once the count is full.
						if (count_q != '1) begin
							count_q <= count_q + CNT_W'(1);
							sum_q   <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
							if (count_q == '0 || sample_ns < min_q) begin
								min_q <= sample_ns;
							end
							if (sample_ns > max_q) begin
								max_q <= sample_ns;
							end
							sample_q <= sample_ns;
							idx_q    <= '0;
							bit_q    <= MSB_BIT;
							state_q  <= S_SEARCH;
						end
					end else if (accept && mode) begin
						qf_q    <= (quantile_fraction > lbh_pkg::Q_ONE) ? lbh_pkg::Q_ONE
						                                                : quantile_fraction;
						state_q <= (count_q == '0) ? S_RESULT : S_MUL;
					end
				end
				S_SEARCH: begin
					if (cand_hit) begin
						idx_q <= cand;
					end
					bit_q <= bit_q >> 1;
					if (bit_q[0]) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					state_q <= S_IDLE;
				end
				S_MUL: begin
					prod_q  <= PROD_W'(qf_q) * PROD_W'(count_q);
					state_q <= S_CEIL;
				end
				S_CEIL: begin
					target_q <= target_n;
					idx_q    <= '0;
					cum_q    <= '0;
					rvld_s1  <= 1'b0;
					state_q  <= S_WALK;
				end
				S_WALK: begin
					// Issue one read a cycle; hold the pointer on the last bucket.
					if (idx_q != LAST) begin
						idx_q <= idx_q + IDXW'(1);
					end
					rvld_s1    <= 1'b1;
					dat_idx_s1 <= idx_q;
					if (rvld_s1) begin
						cum_q <= cum_add[CNT_W-1:0];
					end
					if (walk_stop) begin
						found_q <= dat_idx_s1;
						rvld_s1 <= 1'b0;
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					result_valid_q <= 1'b1;
					quantile_q     <= quantile_n;
					sample_count_q <= count_q;
					sum_out_q      <= sum_q;
					min_out_q      <= min_q;
					max_out_q      <= max_q;
					state_q        <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign quantile_ns  = quantile_q;
	assign sample_count = sample_count_q;
	assign sum_ns       = sum_out_q;
	assign min_ns       = min_out_q;
	assign max_ns       = max_out_q;

	`LBH_ASSERT(a_result_pulse, result_valid |=> !result_valid, "result strobe held")
	`LBH_ASSERT(a_result_src, result_valid |-> $past(state_q == S_RESULT), "stray result")
	`LBH_NEVER(a_we_state, ram_we && state_q != S_WR && state_q != S_CLEAR, "stray RAM write")
	`LBH_ASSERT(a_cnt_step, !$stable(count_q) |-> count_q == $past(count_q) + CNT_W'(1), "count jump")
	`LBH_ASSERT(a_min_max, (count_q != '0) |-> (min_q <= max_q), "min above max")

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// Latency histogram testbench
// Drives add and quantile beats into the quarter-octave histogram, predicts
// every query report from a private copy of the bucket store and summary
// statistics, and checks each report field by field as it is strobed out.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_BINS       = lbh_pkg::BUCKETS_DEF;
	localparam int NS_W         = lbh_pkg::NS_W;
	localparam int CNT_W        = lbh_pkg::CNT_W;
	localparam int SUM_W        = lbh_pkg::SUM_W;
	localparam int QF_W         = lbh_pkg::QF_W;
	localparam int RANDOM_BEATS = 530;
	// A short run of full-scale samples near the end.
	localparam int SAT_BEATS    = 8;
	// The limit sits above the slowest correct run: about 560 beats, each with its busy
	// time and an idle gap, plus the clearing pass and the drain.
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int REPORT_MAX   = 10;

	localparam logic [NS_W-1:0] NS_FULL   = '1;
	localparam logic [QF_W-1:0] FRAC_ONE  = QF_W'(65536);
	localparam logic [QF_W-1:0] FRAC_HALF = QF_W'(32768);
	localparam logic [QF_W-1:0] FRAC_TOP  = '1;

	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct {
		logic [NS_W-1:0]  quantile;
		logic [CNT_W-1:0] count;
		logic [SUM_W-1:0] sum;
		logic [NS_W-1:0]  low;
		logic [NS_W-1:0]  high;
	} stats_report_t;

	// Private histogram: mirrors the bucket store and the summary statistics,
	// and queues the report that each accepted query must produce.
	class hist_checker;
		logic [NS_W:0]    bound_tab [N_BINS-1];
		logic [CNT_W-1:0] bin_count [N_BINS];
		logic [CNT_W-1:0] n_samples;
		logic [SUM_W-1:0] sum_total;
		logic [NS_W-1:0]  low_water;
		logic [NS_W-1:0]  high_water;
		stats_report_t    pending_reports [$];
		int               errors;

		function new();
			logic [127:0] whole;
			logic [127:0] frac18;
			logic [127:0] v;
			int           m;
			for (int k = 0; k < N_BINS - 1; k++) begin
				// 10000 * 2^(r/4) as integer part plus 18 decimal digits of fraction
				case (k % 4)
					0: begin
						whole = 128'd10000; frac18 = 128'd0;
					end
					1: begin
						whole = 128'd11892; frac18 = 128'd071150027210667175;
					end
					2: begin
						whole = 128'd14142; frac18 = 128'd135623730950488017;
					end
					default: begin
						whole = 128'd16817; frac18 = 128'd928305074290860623;
					end
				endcase
				m = k / 4;
				if (m > 34) begin
					bound_tab[k] = {1'b1, {NS_W{1'b0}}};
				end else begin
					// Round half up of the scaled fraction, then clamp at 2^48.
					v = (whole << m) + (((frac18 << m) + 128'd500000000000000000)
						/ 128'd1000000000000000000);
					bound_tab[k] = (v > (128'd1 << NS_W)) ? {1'b1, {NS_W{1'b0}}}
						: v[NS_W:0];
				end
			end
			foreach (bin_count[i]) bin_count[i] = '0;
			n_samples  = '0;
			sum_total  = '0;
			low_water  = '0;
			high_water = '0;
			errors     = 0;
		endfunction

		function int bin_of(logic [NS_W-1:0] smp);
			int idx;
			idx = 0;
			for (int k = 0; k < N_BINS - 1; k++) begin
				if ({1'b0, smp} >= bound_tab[k]) idx = k + 1;
				else break;
			end
			return idx;
		endfunction

		function logic [NS_W-1:0] quantile_estimate(logic [QF_W-1:0] qf);
			logic [QF_W-1:0] frac;
			logic [63:0]     target;
			logic [63:0]     running;
			if (n_samples == '0) return '0;
			frac    = (qf > FRAC_ONE) ? FRAC_ONE : qf;
			target  = (64'(frac) * 64'(n_samples) + 64'd65535) >> 16;
			if (target == '0) target = 64'd1;
			running = '0;
			for (int i = 0; i < N_BINS; i++) begin
				running += 64'(bin_count[i]);
				if (running >= target) begin
					if (i == N_BINS - 1) return high_water;
					return ({1'b0, high_water} < bound_tab[i]) ? high_water
						: bound_tab[i][NS_W-1:0];
				end
			end
			return high_water;
		endfunction

		function void note_beat(op_t op, logic [NS_W-1:0] smp, logic [QF_W-1:0] qf);
			logic [SUM_W:0] wide_sum;
			stats_report_t  rep;
			if (op == OP_ADD) begin
				// Drop the sample once the count is full.
				if (n_samples == '1) return;
				if (n_samples == '0 || smp < low_water) low_water = smp;
				if (smp > high_water) high_water = smp;
				n_samples++;
				wide_sum  = {1'b0, sum_total} + (SUM_W + 1)'(smp);
				sum_total = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
				bin_count[bin_of(smp)]++;
			end else begin
				rep.quantile = quantile_estimate(qf);
				rep.count    = n_samples;
				rep.sum      = sum_total;
				rep.low      = low_water;
				rep.high     = high_water;
				pending_reports.push_back(rep);
			end
		endfunction

		function void check_result(logic [NS_W-1:0] q, logic [CNT_W-1:0] c,
			logic [SUM_W-1:0] s, logic [NS_W-1:0] lo, logic [NS_W-1:0] hi);
			stats_report_t rep;
			if (pending_reports.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected report: q=%0d count=%0d sum=%0d min=%0d max=%0d",
						q, c, s, lo, hi);
				return;
			end
			rep = pending_reports.pop_front();
			if (q !== rep.quantile || c !== rep.count || s !== rep.sum
				|| lo !== rep.low || hi !== rep.high) begin
				errors++;
				if (errors <= REPORT_MAX) begin
					$display("report mismatch (expected / actual):");
					$display("  quantile_ns  %0d / %0d", rep.quantile, q);
					$display("  sample_count %0d / %0d", rep.count, c);
					$display("  sum_ns       %0d / %0d", rep.sum, s);
					$display("  min_ns       %0d / %0d", rep.low, lo);
					$display("  max_ns       %0d / %0d", rep.high, hi);
				end
			end
		endfunction

		function int pending();
			return pending_reports.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             mode;
	logic [NS_W-1:0]  sample_ns;
	logic [QF_W-1:0]  quantile_fraction;
	logic             result_valid;
	logic [NS_W-1:0]  quantile_ns;
	logic [CNT_W-1:0] sample_count;
	logic [SUM_W-1:0] sum_ns;
	logic [NS_W-1:0]  min_ns;
	logic [NS_W-1:0]  max_ns;
	int               cycle_count;

	hist_checker sb = new();

	log_bucket_latency_histogram_top #(
		.BUCKETS(N_BINS)
	) u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.mode              (mode),
		.sample_ns         (sample_ns),
		.quantile_fraction (quantile_fraction),
		.result_valid      (result_valid),
		.quantile_ns       (quantile_ns),
		.sample_count      (sample_count),
		.sum_ns            (sum_ns),
		.min_ns            (min_ns),
		.max_ns            (max_ns)
	);

	always #1 clk = ~clk;

	// Results cannot be held off: take every strobed report at the edge that ends it.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1)
			sb.check_result(quantile_ns, sample_count, sum_ns, min_ns, max_ns);
	end

	// Watchdog: stop a run that hangs on a handshake.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb failed");
		$finish;
	end

	// Present one beat and hold it until the block takes it, then note it.
	task automatic issue_beat(input op_t op, input logic [NS_W-1:0] smp,
		input logic [QF_W-1:0] qf);
		start             <= 1'b1;
		mode              <= op;
		sample_ns         <= smp;
		quantile_fraction <= qf;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_beat(op, smp, qf);
	endtask

	// Idle the sender about a third of the time, mostly short gaps, sometimes
	// long enough to outlast a full query walk. Junk sits on the data ports.
	task automatic pace(input bit calm);
		int gap;
		if (!calm && $urandom_range(0, 99) < 33) begin
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 160)
				: $urandom_range(1, 8);
			start             <= 1'b0;
			mode              <= $urandom_range(0, 1);
			sample_ns         <= NS_W'({$urandom(), $urandom()});
			quantile_fraction <= QF_W'($urandom());
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		op_t             op;
		logic [NS_W-1:0] smp;
		logic [QF_W-1:0] qf;
		logic [NS_W:0]   b;
		int              pick;

		arst_n            <= 1'b0;
		start             <= 1'b0;
		mode              <= OP_ADD;
		sample_ns         <= '0;
		quantile_fraction <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// The clearing pass keeps busy high; the handshake waits it out.
		@(posedge clk);

		// Empty store: every field reads zero, whatever the fraction.
		issue_beat(OP_QUERY, '0, '0);
		pace(1'b0);
		issue_beat(OP_QUERY, '0, FRAC_ONE);
		issue_beat(OP_QUERY, NS_FULL, FRAC_TOP);

		// Sample extremes and the edges of the first buckets.
		issue_beat(OP_ADD, '0, '0);
		issue_beat(OP_ADD, NS_W'(9999), '0);
		pace(1'b0);
		issue_beat(OP_ADD, NS_W'(10000), '0);
		issue_beat(OP_ADD, NS_W'(10001), FRAC_TOP);
		issue_beat(OP_ADD, NS_W'(1), '0);
		issue_beat(OP_ADD, sb.bound_tab[5][NS_W-1:0] - NS_W'(1), '0);
		pace(1'b0);
		issue_beat(OP_ADD, sb.bound_tab[5][NS_W-1:0], '0);
		issue_beat(OP_ADD, NS_FULL, '0);
		issue_beat(OP_ADD, NS_W'(123456789), '0);

		// Fractions at zero, one step, half, just under one, one and above one.
		issue_beat(OP_QUERY, '0, '0);
		issue_beat(OP_QUERY, '0, QF_W'(1));
		pace(1'b0);
		issue_beat(OP_QUERY, '0, FRAC_HALF);
		issue_beat(OP_QUERY, '0, QF_W'(65535));
		issue_beat(OP_QUERY, '0, FRAC_ONE);
		issue_beat(OP_QUERY, '0, QF_W'(65537));
		issue_beat(OP_QUERY, '0, FRAC_TOP);
		issue_beat(OP_QUERY, NS_FULL, QF_W'(6000));

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			// A calm stretch with back-to-back beats.
			pace(i >= 180 && i < 300);
			// Once, hold off until every pending report has come back.
			if (i == 400) begin
				start <= 1'b0;
				do @(posedge clk); while (sb.pending() != 0);
			end

			op   = ($urandom_range(0, 4) == 0) ? OP_QUERY : OP_ADD;
			pick = $urandom_range(0, 9);
			case (pick)
				0: smp = NS_W'($urandom_range(0, 20000));
				1: begin
					// Land on, just under or just over a bucket bound.
					b = sb.bound_tab[$urandom_range(0, N_BINS - 2)];
					if (b[NS_W]) smp = NS_FULL;
					else smp = b[NS_W-1:0] + NS_W'($urandom_range(0, 2)) - NS_W'(1);
				end
				2: smp = NS_W'({$urandom(), $urandom()});
				default: smp = NS_W'({$urandom(), $urandom()}) >> $urandom_range(0, 47);
			endcase

			pick = $urandom_range(0, 9);
			case (pick)
				0: qf = QF_W'($urandom());
				1: begin
					case ($urandom_range(0, 5))
						0: qf = '0;
						1: qf = QF_W'(1);
						2: qf = QF_W'(65535);
						3: qf = FRAC_ONE;
						4: qf = QF_W'(65537);
						default: qf = FRAC_TOP;
					endcase
				end
				default: qf = QF_W'($urandom_range(0, 65536));
			endcase

			issue_beat(op, smp, qf);
		end

		// Finish with full-scale samples on top of the random ones.
		for (int i = 0; i < SAT_BEATS; i++)
			issue_beat(OP_ADD, NS_FULL, '0);
		issue_beat(OP_ADD, NS_W'(7), '0);
		issue_beat(OP_QUERY, '0, '0);
		issue_beat(OP_QUERY, '0, FRAC_HALF);
		pace(1'b0);
		issue_beat(OP_QUERY, '0, FRAC_ONE);
		issue_beat(OP_QUERY, '0, FRAC_TOP);

		// Drain: wait for the last report, then let any trailing walk settle.
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (N_BINS + 8) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/lbh_pkg.sv
hdl/lbh_ram.sv
hdl/log_bucket_latency_histogram_top.sv
bench/tb.sv
